/* sv/date_to_epoch_seconds_tz_assert.svh */
// Assertion macros used by the checker file of the date conversion block.
`ifndef DATE_TO_EPOCH_SECONDS_TZ_ASSERT_SVH
`define DATE_TO_EPOCH_SECONDS_TZ_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTES_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dtes_pkg.sv */
package dtes_pkg;

	localparam logic [11:0] EpochYear   = 12'd1970;
	localparam logic [6:0]  EpochMod100 = 7'd70;
	localparam logic [8:0]  EpochMod400 = 9'd370;
	localparam logic [6:0]  Last100     = 7'd99;
	localparam logic [8:0]  Last400     = 9'd399;
	localparam logic [8:0]  DaysLeap    = 9'd366;
	localparam logic [8:0]  DaysCommon  = 9'd365;
	localparam logic [3:0]  MonthFeb    = 4'd2;
	localparam logic [3:0]  MonthLast   = 4'd12;

	// Reciprocal of 100 scaled by 2^19, exact for four-digit years.
	localparam logic [12:0] Recip100    = 13'd5243;
	localparam int          RecipShift  = 19;
	localparam logic [6:0]  Hundred     = 7'd100;

	localparam logic signed [17:0] SecPerDay  = 18'sd86400;
	localparam logic [11:0]        SecPerHour = 12'd3600;
	localparam logic [5:0]         SecPerMin  = 6'd60;

	localparam logic [2:0] ZoneUtc  = 3'd0;
	localparam logic [2:0] ZoneCet  = 3'd1;
	localparam logic [2:0] ZoneEst  = 3'd2;
	localparam logic [2:0] ZonePst  = 3'd3;
	localparam logic [2:0] ZoneJst  = 3'd4;
	localparam logic [2:0] ZoneAest = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_DAY,
		ST_MUL,
		ST_HOUR,
		ST_MINUTE,
		ST_SECOND,
		ST_ZONE,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_ADD,
		OP_DAY,
		OP_MUL,
		OP_HOUR,
		OP_MINUTE,
		OP_SECOND,
		OP_ZONE,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [8:0] days;
	} ctl_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd2:                      len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			default:                   len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic summer_of(input logic [2:0] z, input logic [3:0] m,
			input logic [4:0] d);
		logic eu;
		logic us;
		logic au;
		logic s;
		eu = (m >= 4'd3) && (m <= 4'd10) &&
			(((m > 4'd3) && (m < 4'd10)) || ((m == 4'd3) ? (d >= 5'd25) : (d < 5'd25)));
		us = (m >= 4'd3) && (m <= 4'd11) &&
			(((m > 4'd3) && (m < 4'd11)) || ((m == 4'd3) ? (d >= 5'd8) : (d < 5'd7)));
		au = (m < 4'd4) || (m > 4'd9) || ((m == 4'd4) && (d < 5'd7));
		unique case (z)
			ZoneCet:          s = eu;
			ZoneEst, ZonePst: s = us;
			ZoneAest:         s = au;
			default:          s = 1'b0;
		endcase
		return s;
	endfunction

	function automatic logic signed [16:0] zone_offset(input logic [2:0] z, input logic s);
		logic signed [16:0] off;
		unique case (z)
			ZoneUtc:  off = 17'sd0;
			ZoneCet:  off = s ? 17'sd7200 : 17'sd3600;
			ZoneEst:  off = s ? -17'sd14400 : -17'sd18000;
			ZonePst:  off = s ? -17'sd25200 : -17'sd28800;
			ZoneJst:  off = 17'sd32400;
			ZoneAest: off = s ? 17'sd39600 : 17'sd36000;
			default:  off = 17'sd0;
		endcase
		return off;
	endfunction

endpackage

/* sv/date_to_epoch_seconds_tz.sv */
// Calendar date and time to seconds since 1970-01-01 with a zone offset added.
// Input channel: item_valid / item_stall carry one word of sec, minute_of_hour,
// hour_of_day, day_of_month, month_of_year, full_year and zone.
// Output channel: result_valid / result_stall carry epoch_seconds (33-bit two's
// complement) and dst_active, one word for each input word, in order.
// One adder walks the year, then month, then day, hour, minute, second and
// zone terms, one per cycle; the day count is scaled by 86400 before the hour
// term. The year walk covers full_year - 1970 years (none for earlier years)
// and the month walk at most 12 earlier months.
// item_stall is high from acceptance until the result is loaded into the
// output register, so one word is in work at a time.
// When the receiver stalls, the result holds in the output register; the
// next word is still accepted and waits at its end until the register frees.
// Reset clears the sequencer and result_valid; the other registers are not reset.
module date_to_epoch_seconds_tz import dtes_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [5:0]         sec,
	input  logic [5:0]         minute_of_hour,
	input  logic [4:0]         hour_of_day,
	input  logic [4:0]         day_of_month,
	input  logic [3:0]         month_of_year,
	input  logic [11:0]        full_year,
	input  logic [2:0]         zone,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [32:0] epoch_seconds,
	output logic               dst_active
);

	ctl_t ctl;

	dtes_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.full_year     (full_year),
		.month_of_year (month_of_year),
		.result_stall  (result_stall),
		.item_stall    (item_stall),
		.result_valid  (result_valid),
		.ctl           (ctl)
	);

	dtes_dpath u_dpath (
		.clk            (clk),
		.ctl            (ctl),
		.sec            (sec),
		.minute_of_hour (minute_of_hour),
		.hour_of_day    (hour_of_day),
		.day_of_month   (day_of_month),
		.month_of_year  (month_of_year),
		.zone           (zone),
		.epoch_seconds  (epoch_seconds),
		.dst_active     (dst_active)
	);

endmodule

/* sv/dtes_ctrl.sv */
module dtes_ctrl import dtes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic [11:0] full_year,
	input  logic [3:0]  month_of_year,
	input  logic        result_stall,
	output logic        item_stall,
	output logic        result_valid,
	output ctl_t        ctl
);

	state_t      state_q;
	state_t      state_nxt;
	logic [11:0] yr_q;
	logic [3:0]  mo_q;
	logic [11:0] y_q;
	logic [6:0]  c100_q;
	logic [8:0]  c400_q;
	logic [5:0]  cent_q;
	logic [3:0]  m_q;
	logic        leap_yr_q;
	logic        result_valid_q;
	logic [24:0] recip;
	logic [12:0] cent_x100;
	logic        leap_y;
	logic        leap_yr;
	logic        year_go;
	logic        month_go;
	logic        out_free;

	assign recip     = full_year * Recip100;
	assign cent_x100 = cent_q * Hundred;
	assign leap_y    = ((y_q[1:0] == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);
	assign leap_yr   = (yr_q[1:0] == 2'd0) &&
		((cent_x100 != {1'b0, yr_q}) || (cent_q[1:0] == 2'd0));
	assign year_go   = y_q < yr_q;
	assign month_go  = (m_q < mo_q) && (m_q <= MonthLast);
	assign out_free  = !result_valid_q || !result_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (item_valid) state_nxt = ST_YEAR;
			ST_YEAR:   if (!year_go) state_nxt = ST_MONTH;
			ST_MONTH:  if (!month_go) state_nxt = ST_DAY;
			ST_DAY:    state_nxt = ST_MUL;
			ST_MUL:    state_nxt = ST_HOUR;
			ST_HOUR:   state_nxt = ST_MINUTE;
			ST_MINUTE: state_nxt = ST_SECOND;
			ST_SECOND: state_nxt = ST_ZONE;
			ST_ZONE:   state_nxt = ST_DONE;
			ST_DONE:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.op   = OP_NONE;
		ctl.days = '0;
		unique case (state_q)
			ST_IDLE:   if (item_valid) ctl.op = OP_LOAD;
			ST_YEAR: begin
				if (year_go) begin
					ctl.op   = OP_ADD;
					ctl.days = leap_y ? DaysLeap : DaysCommon;
				end
			end
			ST_MONTH: begin
				if (month_go) begin
					ctl.op   = OP_ADD;
					ctl.days = {4'd0, month_len(m_q)} +
						{8'd0, (m_q == MonthFeb) && leap_yr_q};
				end
			end
			ST_DAY:    ctl.op = OP_DAY;
			ST_MUL:    ctl.op = OP_MUL;
			ST_HOUR:   ctl.op = OP_HOUR;
			ST_MINUTE: ctl.op = OP_MINUTE;
			ST_SECOND: ctl.op = OP_SECOND;
			ST_ZONE:   ctl.op = OP_ZONE;
			ST_DONE:   if (out_free) ctl.op = OP_OUT;
			default:   ctl.op = OP_NONE;
		endcase
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.op == OP_OUT) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				yr_q   <= full_year;
				mo_q   <= month_of_year;
				y_q    <= EpochYear;
				c100_q <= EpochMod100;
				c400_q <= EpochMod400;
				cent_q <= recip[RecipShift +: 6];
			end
			ST_YEAR: begin
				leap_yr_q <= leap_yr;
				m_q       <= 4'd1;
				if (year_go) begin
					y_q    <= y_q + 12'd1;
					c100_q <= (c100_q == Last100) ? 7'd0 : c100_q + 7'd1;
					c400_q <= (c400_q == Last400) ? 9'd0 : c400_q + 9'd1;
				end
			end
			ST_MONTH: if (month_go) m_q <= m_q + 4'd1;
			default: begin
			end
		endcase
	end

endmodule

/* sv/dtes_dpath.sv */
module dtes_dpath import dtes_pkg::*; (
	input  logic               clk,
	input  ctl_t               ctl,
	input  logic [5:0]         sec,
	input  logic [5:0]         minute_of_hour,
	input  logic [4:0]         hour_of_day,
	input  logic [4:0]         day_of_month,
	input  logic [3:0]         month_of_year,
	input  logic [2:0]         zone,
	output logic signed [32:0] epoch_seconds,
	output logic               dst_active
);

	logic [5:0]         sec_q;
	logic [5:0]         min_q;
	logic [4:0]         hour_q;
	logic [4:0]         day_q;
	logic signed [16:0] off_q;
	logic               summer_q;
	logic signed [32:0] acc_q;
	logic signed [32:0] epoch_q;
	logic               dst_q;
	logic               summer_in;
	logic signed [32:0] addend;
	logic signed [39:0] product;
	logic [16:0]        hour_secs;
	logic [11:0]        min_secs;

	assign summer_in = summer_of(zone, month_of_year, day_of_month);
	assign hour_secs = hour_q * SecPerHour;
	assign min_secs  = min_q * SecPerMin;
	assign product   = $signed(acc_q[21:0]) * SecPerDay;

	always_comb begin
		unique case (ctl.op)
			OP_ADD:    addend = {24'd0, ctl.days};
			OP_DAY:    addend = $signed({28'd0, day_q}) - 33'sd1;
			OP_HOUR:   addend = {16'd0, hour_secs};
			OP_MINUTE: addend = {21'd0, min_secs};
			OP_SECOND: addend = {27'd0, sec_q};
			OP_ZONE:   addend = {{16{off_q[16]}}, off_q};
			default:   addend = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				sec_q    <= sec;
				min_q    <= minute_of_hour;
				hour_q   <= hour_of_day;
				day_q    <= day_of_month;
				summer_q <= summer_in;
				off_q    <= zone_offset(zone, summer_in);
				acc_q    <= '0;
			end
			OP_MUL: acc_q <= product[32:0];
			OP_OUT: begin
				epoch_q <= acc_q;
				dst_q   <= summer_q;
			end
			OP_ADD, OP_DAY, OP_HOUR, OP_MINUTE, OP_SECOND, OP_ZONE: acc_q <= acc_q + addend;
			default: begin
			end
		endcase
	end

	assign epoch_seconds = epoch_q;
	assign dst_active    = dst_q;

endmodule

/* sv/dtes_checker.sv */
`include "date_to_epoch_seconds_tz_assert.svh"

module dtes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [32:0] epoch_seconds,
	input logic        dst_active
);

	`DTES_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(epoch_seconds) && $stable(dst_active), "stalled result word changed")
	`DTES_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "block ready straight after accepting a word")
	`DTES_ASSERT_NEXT(a_no_instant_result, item_valid && !item_stall, !$rose(result_valid), "result appeared one cycle after acceptance")
	`DTES_ASSERT_SAME(a_idle_on_result, $rose(result_valid), !item_stall, "block not ready when its result was issued")

endmodule

bind date_to_epoch_seconds_tz dtes_checker u_dtes_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import dtes_pkg::*;

	localparam logic [2:0] ZoneSpare6 = 3'd6;
	localparam logic [2:0] ZoneSpare7 = 3'd7;
	localparam int WinterOffset [6] = '{0, 3600, -18000, -28800, 32400, 36000};
	localparam int SummerOffset [6] = '{0, 7200, -14400, -25200, 32400, 39600};
	localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int DirectedCount = 25;
	localparam int WordsPerPhase = 250;
	localparam int LongHold = 400;
	localparam int CycleLimit = 3000000;

	typedef enum int {
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} load_phase_t;

	typedef struct packed {
		logic [32:0] epoch;
		logic        dst;
	} stamp_t;

	typedef struct packed {
		logic [5:0]  s;
		logic [5:0]  mi;
		logic [4:0]  h;
		logic [4:0]  d;
		logic [3:0]  mo;
		logic [11:0] yr;
		logic [2:0]  z;
		logic        known;
		logic [32:0] epoch;
		logic        dst;
	} date_row_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic [5:0]         sec;
	logic [5:0]         minute_of_hour;
	logic [4:0]         hour_of_day;
	logic [4:0]         day_of_month;
	logic [3:0]         month_of_year;
	logic [11:0]        full_year;
	logic [2:0]         zone;
	logic               result_valid;
	logic               result_stall;
	logic signed [32:0] epoch_seconds;
	logic               dst_active;

	stamp_t      pending_stamps [$];
	int          fault_count = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	bit          hold_done = 0;
	load_phase_t phase = PH_FREE;

	// Boundary words: the first and last instants of the range, unused zones, day zero,
	// each daylight-saving edge and months outside the calendar.
	date_row_t directed_rows [DirectedCount] = '{
		'{6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 12'd1970, ZoneUtc, 1'b1, 33'sd0, 1'b0},
		'{6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 12'd1970, ZonePst, 1'b1, -33'sd28800, 1'b0},
		'{6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 12'd2099, ZoneUtc, 1'b1, 33'sd4102444799, 1'b0},
		'{6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 12'd2099, ZoneAest, 1'b1, 33'sd4102484399, 1'b1},
		'{6'd1, 6'd0, 5'd0, 5'd1, 4'd1, 12'd1970, ZoneSpare6, 1'b1, 33'sd1, 1'b0},
		'{6'd0, 6'd0, 5'd1, 5'd1, 4'd7, 12'd1970, ZoneSpare7, 1'b0, 33'sd0, 1'b0},
		'{6'd0, 6'd0, 5'd0, 5'd0, 4'd1, 12'd1970, ZoneUtc, 1'b1, -33'sd86400, 1'b0},
		'{6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 12'd0, ZoneUtc, 1'b1, -33'sd86400, 1'b0},
		'{6'd0, 6'd0, 5'd12, 5'd24, 4'd3, 12'd2021, ZoneCet, 1'b0, 33'sd0, 1'b0},
		'{6'd0, 6'd0, 5'd12, 5'd25, 4'd3, 12'd2021, ZoneCet, 1'b0, 33'sd0, 1'b0},
		'{6'd0, 6'd0, 5'd12, 5'd24, 4'd10, 12'd2021, ZoneCet, 1'b0, 33'sd0, 1'b0},
		'{6'd0, 6'd0, 5'd12, 5'd25, 4'd10, 12'd2021, ZoneCet, 1'b0, 33'sd0, 1'b0},
		'{6'd30, 6'd15, 5'd6, 5'd7, 4'd3, 12'd2022, ZoneEst, 1'b0, 33'sd0, 1'b0},
		'{6'd30, 6'd15, 5'd6, 5'd8, 4'd3, 12'd2022, ZoneEst, 1'b0, 33'sd0, 1'b0},
		'{6'd30, 6'd15, 5'd6, 5'd6, 4'd11, 12'd2022, ZonePst, 1'b0, 33'sd0, 1'b0},
		'{6'd30, 6'd15, 5'd6, 5'd7, 4'd11, 12'd2022, ZonePst, 1'b0, 33'sd0, 1'b0},
		'{6'd5, 6'd45, 5'd20, 5'd6, 4'd4, 12'd2023, ZoneAest, 1'b0, 33'sd0, 1'b0},
		'{6'd5, 6'd45, 5'd20, 5'd7, 4'd4, 12'd2023, ZoneAest, 1'b0, 33'sd0, 1'b0},
		'{6'd5, 6'd45, 5'd20, 5'd30, 4'd9, 12'd2023, ZoneAest, 1'b0, 33'sd0, 1'b0},
		'{6'd5, 6'd45, 5'd20, 5'd1, 4'd10, 12'd2023, ZoneAest, 1'b0, 33'sd0, 1'b0},
		'{6'd56, 6'd34, 5'd12, 5'd29, 4'd2, 12'd2000, ZoneJst, 1'b0, 33'sd0, 1'b0},
		'{6'd0, 6'd0, 5'd0, 5'd15, 4'd0, 12'd2000, ZoneUtc, 1'b0, 33'sd0, 1'b0},
		'{6'd0, 6'd0, 5'd0, 5'd3, 4'd13, 12'd2001, ZoneUtc, 1'b0, 33'sd0, 1'b0},
		'{6'd9, 6'd9, 5'd9, 5'd31, 4'd15, 12'd1999, ZoneAest, 1'b0, 33'sd0, 1'b0},
		'{6'd63, 6'd63, 5'd31, 5'd31, 4'd15, 12'd4095, ZoneSpare7, 1'b0, 33'sd0, 1'b0}
	};

	date_to_epoch_seconds_tz u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.sec            (sec),
		.minute_of_hour (minute_of_hour),
		.hour_of_day    (hour_of_day),
		.day_of_month   (day_of_month),
		.month_of_year  (month_of_year),
		.full_year      (full_year),
		.zone           (zone),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.epoch_seconds  (epoch_seconds),
		.dst_active     (dst_active)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic stamp_t predict_stamp(input logic [5:0] s, input logic [5:0] mi,
			input logic [4:0] h, input logic [4:0] d, input logic [3:0] mo,
			input logic [11:0] yr, input logic [2:0] z);
		longint days;
		longint total;
		int     offset;
		logic   summer;
		stamp_t stamp;
		days = 0;
		for (int y = 1970; y < int'(yr); y++)
			days += leap_year(y) ? 366 : 365;
		for (int m = 1; m < int'(mo); m++) begin
			if (m <= 12) begin
				days += MonthDays[m - 1];
				if (m == 2 && leap_year(int'(yr)))
					days += 1;
			end
		end
		days += longint'(d) - 1;
		case (z)
			ZoneCet: summer = (mo > 3 && mo < 10) || (mo == 3 && d >= 25) || (mo == 10 && d < 25);
			ZoneEst, ZonePst: summer = (mo > 3 && mo < 11) || (mo == 3 && d >= 8) ||
				(mo == 11 && d < 7);
			ZoneAest: summer = (mo < 4) || (mo > 9) || (mo == 4 && d < 7);
			default: summer = 1'b0;
		endcase
		offset = 0;
		if (z <= ZoneAest)
			offset = summer ? SummerOffset[z] : WinterOffset[z];
		total = days * 86400 + longint'(h) * 3600 + longint'(mi) * 60 + longint'(s) +
			longint'(offset);
		stamp.epoch = total[32:0];
		stamp.dst = summer;
		return stamp;
	endfunction

	task automatic send_word(input logic [5:0] s, input logic [5:0] mi, input logic [4:0] h,
			input logic [4:0] d, input logic [3:0] mo, input logic [11:0] yr,
			input logic [2:0] z, input bit known, input stamp_t known_stamp);
		int gap_pct;
		gap_pct = (phase == PH_SEND_IDLE) ? 66 : (phase == PH_BOTH) ? 7 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		sec <= s;
		minute_of_hour <= mi;
		hour_of_day <= h;
		day_of_month <= d;
		month_of_year <= mo;
		full_year <= yr;
		zone <= z;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_stamps.push_back(known ? known_stamp : predict_stamp(s, mi, h, d, mo, yr, z));
		@(negedge clk);
	endtask

	// The receiver holds off for a long stretch once, at the start of its stalling phase,
	// so that the block fills up while words keep being offered.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (phase == PH_RECV_STALL && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LongHold;
			result_stall <= 1'b1;
		end else begin
			result_stall <= $urandom_range(0, 99) <
				((phase == PH_RECV_STALL) ? 66 : (phase == PH_BOTH) ? 7 : 0);
		end
	end

	always @(posedge clk) begin
		stamp_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_stamps.size() == 0) begin
				$error("epoch_seconds: no word expected, actual %0d", epoch_seconds);
				fault_count++;
			end else begin
				want = pending_stamps.pop_front();
				if (epoch_seconds !== want.epoch) begin
					$error("epoch_seconds: expected %0d, actual %0d", $signed(want.epoch),
						epoch_seconds);
					fault_count++;
				end
				if (dst_active !== want.dst) begin
					$error("dst_active: expected %0b, actual %0b", want.dst, dst_active);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		date_row_t   row;
		stamp_t      typed;
		logic [5:0]  s;
		logic [5:0]  mi;
		logic [4:0]  h;
		logic [4:0]  d;
		logic [3:0]  mo;
		logic [11:0] yr;
		logic [2:0]  z;
		bit          wild;
		arst_n = 1'b0;
		item_valid = 1'b0;
		sec = '0;
		minute_of_hour = '0;
		hour_of_day = '0;
		day_of_month = '0;
		month_of_year = '0;
		full_year = '0;
		zone = '0;
		result_stall = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DirectedCount; i++) begin
			row = directed_rows[i];
			typed.epoch = row.epoch;
			typed.dst = row.dst;
			send_word(row.s, row.mi, row.h, row.d, row.mo, row.yr, row.z, row.known, typed);
		end

		// Mostly calendar-valid words; a few carry arbitrary bit patterns in every field but the
		// year, and a few an arbitrary 12-bit year, which can keep the block busy for much longer.
		for (int p = PH_FREE; p <= PH_BOTH; p++) begin
			item_valid <= 1'b0;
			do
				@(negedge clk);
			while (pending_stamps.size() != 0);
			phase = load_phase_t'(p);
			for (int n = 0; n < WordsPerPhase; n++) begin
				wild = $urandom_range(0, 99) < 5;
				s = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
				mi = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
				h = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
				d = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
				mo = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
				z = wild ? 3'($urandom) : 3'($urandom_range(0, 5));
				yr = ($urandom_range(0, 99) < 3) ? 12'($urandom) : 12'($urandom_range(1970, 2099));
				send_word(s, mi, h, d, mo, yr, z, 1'b0, typed);
			end
		end

		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_stamps.size() != 0);
		repeat (150) @(posedge clk);
		if (fault_count == 0 && pending_stamps.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

/* date_to_epoch_seconds_tz.f */
+incdir+sv
sv/dtes_pkg.sv
sv/dtes_ctrl.sv
sv/dtes_dpath.sv
sv/date_to_epoch_seconds_tz.sv
sv/dtes_checker.sv
tb/testbench.sv
